### rtl/kvt_pkg.sv
`default_nettype none

package kvt_pkg;

  localparam int unsigned KvtEntries = 16;
  localparam int unsigned KeyW       = 32;
  localparam int unsigned ValW       = 32;

  typedef enum logic [1:0] {
    MODE_FIND   = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_NOT_FOUND     = 3'd1,
    ST_EXISTS        = 3'd2,
    ST_INVALID_VALUE = 3'd3,
    ST_FULL          = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_CLEAR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic en;
    logic kv;
    logic valid;
  } mem_wr_t;

  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } mem_rd_t;

  typedef struct packed {
    status_e         status;
    logic [ValW-1:0] value;
  } res_t;

endpackage

`default_nettype wire

### rtl/kvt_mem.sv
`default_nettype none

module kvt_mem import kvt_pkg::*; #(
  parameter int unsigned ENTRIES = KvtEntries,
  parameter int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  wire logic             clk_i,
  input  wire mem_wr_t          wr_i,
  input  wire logic [IDX_W-1:0] wr_addr_i,
  input  wire logic [KeyW-1:0]  wr_key_i,
  input  wire logic [ValW-1:0]  wr_value_i,
  input  wire logic [IDX_W-1:0] rd_addr_i,
  output mem_rd_t               rd_o
);

  logic            valid_mem [ENTRIES];
  logic [KeyW-1:0] key_mem   [ENTRIES];
  logic [ValW-1:0] value_mem [ENTRIES];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      valid_mem[wr_addr_i] <= wr_i.valid;
    end
    if (wr_i.en && wr_i.kv) begin
      key_mem[wr_addr_i]   <= wr_key_i;
      value_mem[wr_addr_i] <= wr_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_o.valid <= valid_mem[rd_addr_i];
    rd_o.key   <= key_mem[rd_addr_i];
    rd_o.value <= value_mem[rd_addr_i];
  end

endmodule

`default_nettype wire

### rtl/kvt_seq.sv
`default_nettype none

module kvt_seq import kvt_pkg::*; #(
  parameter int unsigned ENTRIES = KvtEntries,
  parameter int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             req_valid_i,
  output logic                  req_stall_o,
  input  wire logic [1:0]       mode_i,
  input  wire logic [KeyW-1:0]  key_i,
  input  wire logic [ValW-1:0]  value_i,
  input  wire mem_rd_t          rd_i,
  output logic [IDX_W-1:0]      rd_addr_o,
  output mem_wr_t               wr_o,
  output logic [IDX_W-1:0]      wr_addr_o,
  output logic [KeyW-1:0]       wr_key_o,
  output logic [ValW-1:0]       wr_value_o,
  output logic                  res_valid_o,
  output res_t                  res_o,
  input  wire logic             res_free_i
);

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] CntEnd  = CNT_W'(ENTRIES);
  localparam logic [CNT_W-1:0] CntLast = CNT_W'(ENTRIES - 1);
  localparam logic [IDX_W-1:0] IdxLast = IDX_W'(ENTRIES - 1);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]  cmp_idx_q, cmp_idx_d;
  logic              free_found_q, free_found_d;
  logic [IDX_W-1:0]  free_idx_q, free_idx_d;
  mode_e             mode_q, mode_d;
  logic [KeyW-1:0]   key_q, key_d;
  logic [ValW-1:0]   value_q, value_d;
  res_t              res_q, res_d;

  logic hit;
  logic free_now;
  logic last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      cnt_q        <= '0;
      cmp_vld_q    <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      cmp_vld_q    <= cmp_vld_d;
      free_found_q <= free_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q  <= cmp_idx_d;
    free_idx_q <= free_idx_d;
    mode_q     <= mode_d;
    key_q      <= key_d;
    value_q    <= value_d;
    res_q      <= res_d;
  end

  assign hit      = cmp_vld_q && rd_i.valid && (rd_i.key == key_q);
  assign free_now = cmp_vld_q && !rd_i.valid;
  assign last     = cmp_vld_q && (cmp_idx_q == IdxLast);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    cmp_vld_d    = 1'b0;
    cmp_idx_d    = cnt_q[IDX_W-1:0];
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    mode_d       = mode_q;
    key_d        = key_q;
    value_d      = value_q;
    res_d        = res_q;
    req_stall_o  = 1'b1;
    res_valid_o  = 1'b0;
    rd_addr_o    = cnt_q[IDX_W-1:0];
    wr_o         = '0;
    wr_addr_o    = cnt_q[IDX_W-1:0];
    wr_key_o     = key_q;
    wr_value_o   = value_q;

    case (state_q)
      S_INIT: begin
        wr_o.en = 1'b1;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        req_stall_o = 1'b0;
        if (req_valid_i) begin
          mode_d       = mode_e'(mode_i);
          key_d        = key_i;
          value_d      = value_i;
          cnt_d        = '0;
          free_found_d = 1'b0;
          if (mode_e'(mode_i) == MODE_CLEAR) begin
            state_d = S_CLEAR;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cnt_q != CntEnd) begin
          cmp_vld_d = 1'b1;
          cnt_d     = cnt_q + 1'b1;
        end
        if (free_now && !free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = cmp_idx_q;
        end
        if (hit) begin
          state_d      = S_DONE;
          res_d.status = ST_OK;
          res_d.value  = '0;
          case (mode_q)
            MODE_FIND: begin
              res_d.value = rd_i.value;
            end
            MODE_ADD: begin
              res_d.status = ST_EXISTS;
            end
            MODE_REMOVE: begin
              wr_o.en   = 1'b1;
              wr_addr_o = cmp_idx_q;
            end
            default: begin
              res_d.status = ST_OK;
            end
          endcase
        end else if (last) begin
          state_d     = S_DONE;
          res_d.value = '0;
          if (mode_q == MODE_ADD) begin
            if (value_q == '0) begin
              res_d.status = ST_INVALID_VALUE;
            end else if (free_found_q || free_now) begin
              res_d.status = ST_OK;
              wr_o.en      = 1'b1;
              wr_o.kv      = 1'b1;
              wr_o.valid   = 1'b1;
              wr_addr_o    = free_found_q ? free_idx_q : cmp_idx_q;
            end else begin
              res_d.status = ST_FULL;
            end
          end else begin
            res_d.status = ST_NOT_FOUND;
          end
        end
      end
      S_CLEAR: begin
        wr_o.en = 1'b1;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          cnt_d        = '0;
          res_d.status = ST_OK;
          res_d.value  = '0;
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
        cnt_d   = '0;
      end
    endcase
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

### rtl/key_value_table.sv
`default_nettype none

// Channel   Direction  Handshake               Payload
// request   in         in_valid_i / in_stall_o  mode_i, key_i, value_i
// result    out        out_valid_o / out_stall_i status_o, found_value_o
//
// Find, add and remove scan every slot through one read port and one key
// comparator, one slot a cycle; a hit ends the scan early. Clear writes one
// valid mark a cycle. After reset the valid marks are cleared before a request
// is taken. The result register lets the next request start while a result
// is stalled; a second result then waits until the first has been taken.

module key_value_table import kvt_pkg::*; #(
  parameter int unsigned ENTRIES = KvtEntries
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [1:0]             mode_i,
  input  wire logic signed [KeyW-1:0] key_i,
  input  wire logic [ValW-1:0]        value_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [2:0]                  status_o,
  output logic [ValW-1:0]             found_value_o
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  mem_rd_t          rd;
  mem_wr_t          wr;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic [KeyW-1:0]  wr_key;
  logic [ValW-1:0]  wr_value;
  logic             res_valid;
  res_t             res;
  logic             res_free;

  logic             out_valid_q;
  logic [2:0]       status_q;
  logic [ValW-1:0]  found_q;

  assign res_free = !out_valid_q || !out_stall_i;

  kvt_seq #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_stall_o (in_stall_o),
    .mode_i      (mode_i),
    .key_i       ($unsigned(key_i)),
    .value_i     (value_i),
    .rd_i        (rd),
    .rd_addr_o   (rd_addr),
    .wr_o        (wr),
    .wr_addr_o   (wr_addr),
    .wr_key_o    (wr_key),
    .wr_value_o  (wr_value),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_free_i  (res_free)
  );

  kvt_mem #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_mem (
    .clk_i      (clk_i),
    .wr_i       (wr),
    .wr_addr_i  (wr_addr),
    .wr_key_i   (wr_key),
    .wr_value_i (wr_value),
    .rd_addr_i  (rd_addr),
    .rd_o       (rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_free) begin
      status_q <= res.status;
      found_q  <= res.value;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_value_o = found_q;

endmodule

`default_nettype wire

### rtl/kvt_checker.sv
`default_nettype none

module kvt_checker import kvt_pkg::*; (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_valid_i,
  input wire logic                   in_stall_o,
  input wire logic                   out_valid_o,
  input wire logic                   out_stall_i,
  input wire logic [2:0]             status_o,
  input wire logic [ValW-1:0]        found_value_o
);

  logic req_acc;

  assign req_acc = in_valid_i && !in_stall_o;

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(found_value_o))
    else $error("A stalled result changed.");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK || status_o == ST_NOT_FOUND || status_o == ST_EXISTS
                     || status_o == ST_INVALID_VALUE || status_o == ST_FULL))
    else $error("A result carries an unknown status.");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> found_value_o == '0)
    else $error("A failed request returned a nonzero value.");

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> in_stall_o)
    else $error("A request was taken while the previous one was still in progress.");

endmodule

bind key_value_table kvt_checker u_kvt_checker (.*);

`default_nettype wire
